>>> design/assert_macros.svh
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked in the same cycle
`define ASSERT_SAME(name, pre, post) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("assertion failed");

// implication checked in the next cycle
`define ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error("assertion failed");

`endif

>>> design/bdks_pkg.sv
// package with operation and status codes and the cell control type
`timescale 1ns / 1ps

package bdks_pkg;

    typedef enum logic [2:0] {
        OP_PUSH_FRONT = 3'd0,
        OP_PUSH_BACK  = 3'd1,
        OP_POP_BACK   = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_REMOVE_KEY = 3'd4,
        OP_SEARCH_KEY = 3'd5
    } t_op;

    localparam int OP_BITS     = 3;
    localparam int STATUS_BITS = 2;
    localparam int COUNT_BITS  = 5;

    localparam logic [STATUS_BITS-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_BITS-1:0] ST_EMPTY   = 2'd1;
    localparam logic [STATUS_BITS-1:0] ST_FULL    = 2'd2;
    localparam logic [STATUS_BITS-1:0] ST_MISSING = 2'd3;

    typedef struct packed {
        logic shift_from_left;
        logic shift_from_right;
        logic shift_after_hit;
        logic load_at_tail;
        logic take_front;
        logic take_tail;
        logic take_hit;
    } t_cell_ctl;

endpackage

>>> design/bdks_cell.sv
// one storage cell of the deque chain with key compare and result forwarding
`timescale 1ns / 1ps

module bdks_cell #(
    parameter int KEY_BITS   = 16,
    parameter int VALUE_BITS = 32,
    parameter int CW         = 5,
    parameter int IDX        = 0
) (
    input  logic                  i_clk,
    input  bdks_pkg::t_cell_ctl   i_ctl,
    input  logic [CW-1:0]         i_count,
    input  logic [KEY_BITS-1:0]   i_find_key,
    input  logic [KEY_BITS-1:0]   i_ins_key,
    input  logic [VALUE_BITS-1:0] i_ins_value,
    input  logic [KEY_BITS-1:0]   i_left_key,
    input  logic [VALUE_BITS-1:0] i_left_value,
    input  logic [KEY_BITS-1:0]   i_right_key,
    input  logic [VALUE_BITS-1:0] i_right_value,
    input  logic                  i_hit,
    output logic                  o_hit,
    input  logic [KEY_BITS-1:0]   i_take_key,
    input  logic [VALUE_BITS-1:0] i_take_value,
    output logic [KEY_BITS-1:0]   o_take_key,
    output logic [VALUE_BITS-1:0] o_take_value,
    output logic [KEY_BITS-1:0]   o_key,
    output logic [VALUE_BITS-1:0] o_value
);

    localparam logic [CW-1:0] L_IDX  = CW'(IDX);
    localparam logic [CW-1:0] L_NEXT = CW'(IDX + 1);
    localparam logic          L_FRONT = (IDX == 0);

    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_BITS-1:0] r_value;
    logic                  w_match;
    logic                  w_take;

    assign w_match = (r_key == i_find_key) && (L_IDX < i_count);
    assign o_hit   = i_hit | w_match;

    assign w_take = (i_ctl.take_front && L_FRONT)
                  | (i_ctl.take_tail && (L_NEXT == i_count))
                  | (i_ctl.take_hit && w_match && !i_hit);

    assign o_take_key   = i_take_key   | (w_take ? r_key   : '0);
    assign o_take_value = i_take_value | (w_take ? r_value : '0);

    assign o_key   = r_key;
    assign o_value = r_value;

    always_ff @(posedge i_clk) begin
        if (i_ctl.shift_from_left) begin
            r_key   <= i_left_key;
            r_value <= i_left_value;
        end else if (i_ctl.shift_from_right || (i_ctl.shift_after_hit && o_hit)) begin
            r_key   <= i_right_key;
            r_value <= i_right_value;
        end else if (i_ctl.load_at_tail && (L_IDX == i_count)) begin
            r_key   <= i_ins_key;
            r_value <= i_ins_value;
        end
    end

endmodule

>>> design/bounded_deque_with_key_search_top.sv
// top level of the bounded deque with key search, built as a chain of cells
// result strobe: o_valid is registered from busy, which is registered from the accepted start
// a new command is accepted only while not busy; the execute step acts on the whole cell chain
// busy is high during the execute cycle; results cannot be stalled
// reset clears the entry count, busy and the result strobe; cell contents stay undefined
`timescale 1ns / 1ps

module bounded_deque_with_key_search_top #(
    parameter int CAPACITY   = 16,
    parameter int KEY_BITS   = 16,
    parameter int VALUE_BITS = 32
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [bdks_pkg::OP_BITS-1:0]       i_operation,
    input  logic [KEY_BITS-1:0]                i_entry_key,
    input  logic [VALUE_BITS-1:0]              i_entry_value,
    output logic                               o_valid,
    output logic [bdks_pkg::STATUS_BITS-1:0]   o_status,
    output logic [KEY_BITS-1:0]                o_out_key,
    output logic [VALUE_BITS-1:0]              o_out_value,
    output logic [bdks_pkg::COUNT_BITS-1:0]    o_entry_count
);

    `include "assert_macros.svh"

    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] L_CAP = CW'(CAPACITY);

    logic                             r_busy;
    bdks_pkg::t_op                    r_op;
    logic [KEY_BITS-1:0]              r_key;
    logic [VALUE_BITS-1:0]            r_value;
    logic [CW-1:0]                    r_count;
    logic [CW-1:0]                    n_count;
    logic [bdks_pkg::STATUS_BITS-1:0] n_status;
    bdks_pkg::t_cell_ctl              w_ctl;
    logic                             w_full;
    logic                             w_empty;
    logic                             w_found;

    logic [KEY_BITS-1:0]   w_key      [CAPACITY];
    logic [VALUE_BITS-1:0] w_value    [CAPACITY];
    logic                  w_hit      [CAPACITY+1];
    logic [KEY_BITS-1:0]   w_take_key [CAPACITY+1];
    logic [VALUE_BITS-1:0] w_take_val [CAPACITY+1];

    assign w_hit[0]      = 1'b0;
    assign w_take_key[0] = '0;
    assign w_take_val[0] = '0;

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic [KEY_BITS-1:0]   w_lk;
            logic [VALUE_BITS-1:0] w_lv;
            logic [KEY_BITS-1:0]   w_rk;
            logic [VALUE_BITS-1:0] w_rv;

            if (g == 0) begin : g_head
                assign w_lk = r_key;
                assign w_lv = r_value;
            end else begin : g_mid
                assign w_lk = w_key[g-1];
                assign w_lv = w_value[g-1];
            end

            if (g == CAPACITY - 1) begin : g_tail
                assign w_rk = w_key[g];
                assign w_rv = w_value[g];
            end else begin : g_body
                assign w_rk = w_key[g+1];
                assign w_rv = w_value[g+1];
            end

            bdks_cell #(
                .KEY_BITS   (KEY_BITS),
                .VALUE_BITS (VALUE_BITS),
                .CW         (CW),
                .IDX        (g)
            ) u_cell (
                .i_clk         (i_clk),
                .i_ctl         (w_ctl),
                .i_count       (r_count),
                .i_find_key    (r_key),
                .i_ins_key     (r_key),
                .i_ins_value   (r_value),
                .i_left_key    (w_lk),
                .i_left_value  (w_lv),
                .i_right_key   (w_rk),
                .i_right_value (w_rv),
                .i_hit         (w_hit[g]),
                .o_hit         (w_hit[g+1]),
                .i_take_key    (w_take_key[g]),
                .i_take_value  (w_take_val[g]),
                .o_take_key    (w_take_key[g+1]),
                .o_take_value  (w_take_val[g+1]),
                .o_key         (w_key[g]),
                .o_value       (w_value[g])
            );
        end
    endgenerate

    assign w_full  = (r_count == L_CAP);
    assign w_empty = (r_count == '0);
    assign w_found = w_hit[CAPACITY];
    assign busy    = r_busy;

    always_comb begin
        w_ctl    = '0;
        n_count  = r_count;
        n_status = bdks_pkg::ST_OK;
        if (r_busy) begin
            case (r_op)
                bdks_pkg::OP_PUSH_FRONT: begin
                    if (w_full) begin
                        n_status = bdks_pkg::ST_FULL;
                    end else begin
                        w_ctl.shift_from_left = 1'b1;
                        n_count = r_count + CW'(1);
                    end
                end
                bdks_pkg::OP_PUSH_BACK: begin
                    if (w_full) begin
                        n_status = bdks_pkg::ST_FULL;
                    end else begin
                        w_ctl.load_at_tail = 1'b1;
                        n_count = r_count + CW'(1);
                    end
                end
                bdks_pkg::OP_POP_BACK: begin
                    if (w_empty) begin
                        n_status = bdks_pkg::ST_EMPTY;
                    end else begin
                        w_ctl.take_tail = 1'b1;
                        n_count = r_count - CW'(1);
                    end
                end
                bdks_pkg::OP_POP_FRONT: begin
                    if (w_empty) begin
                        n_status = bdks_pkg::ST_EMPTY;
                    end else begin
                        w_ctl.take_front       = 1'b1;
                        w_ctl.shift_from_right = 1'b1;
                        n_count = r_count - CW'(1);
                    end
                end
                bdks_pkg::OP_REMOVE_KEY: begin
                    w_ctl.take_hit        = 1'b1;
                    w_ctl.shift_after_hit = 1'b1;
                    if (w_found) begin
                        n_count = r_count - CW'(1);
                    end else begin
                        n_status = bdks_pkg::ST_MISSING;
                    end
                end
                bdks_pkg::OP_SEARCH_KEY: begin
                    w_ctl.take_hit = 1'b1;
                    if (!w_found) begin
                        n_status = bdks_pkg::ST_MISSING;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_count <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= r_busy;
            if (r_busy) begin
                r_busy  <= 1'b0;
                r_count <= n_count;
            end else if (start) begin
                r_busy <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_busy && start) begin
            r_op    <= bdks_pkg::t_op'(i_operation);
            r_key   <= i_entry_key;
            r_value <= i_entry_value;
        end
        if (r_busy) begin
            o_status      <= n_status;
            o_out_key     <= w_take_key[CAPACITY];
            o_out_value   <= w_take_val[CAPACITY];
            o_entry_count <= bdks_pkg::COUNT_BITS'(n_count);
        end
    end

    // command flow: every accepted command produces exactly one strobe
    `ASSERT_NEXT(a_start_to_busy, start && !busy, busy && !o_valid)
    `ASSERT_NEXT(a_busy_to_valid, busy, o_valid && !busy)
    // occupancy never exceeds capacity
    `ASSERT_SAME(a_count_bound, 1'b1, r_count <= L_CAP)
    // failed commands return no entry
    `ASSERT_SAME(a_fail_zero, o_valid && (o_status != bdks_pkg::ST_OK),
                 (o_out_key == '0) && (o_out_value == '0))

endmodule
